// ----- rtl/stereo_feedback_delay_lowpass_macros.svh -----
// ----------------------------------------------------------------------------
// Stereo feedback delay assertion macros
// Assertion helpers for the delay block. They compile to nothing under
// synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_LOWPASS_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_LOWPASS_MACROS_SVH
`ifndef SYNTHESIS
`define SFDL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stereo delay assertion failed");
`define SFDL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stereo delay assertion failed");
`else
`define SFDL_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFDL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/sfdl_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereo feedback delay package
// Register codes, reset values, limits and the sequencer state type.
// ----------------------------------------------------------------------------
package sfdl_pkg;

   typedef enum logic [1:0] {
      CSR_DELAY    = 2'd0,
      CSR_FEEDBACK = 2'd1,
      CSR_WET      = 2'd2,
      CSR_COEFF    = 2'd3
   } csr_index_type;

   localparam int unsigned FB_MAX      = 26214;
   localparam int unsigned UNITY       = 32768;
   localparam int unsigned DELAY_RESET = 12000;
   localparam int unsigned FB_RESET    = 0;
   localparam int unsigned WET_RESET   = 0;
   localparam int unsigned COEFF_RESET = 10643;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_LP,
      ST_ACC_LP,
      ST_MUL_FB,
      ST_ACC_FB,
      ST_MUL_DRY,
      ST_MUL_WET,
      ST_ACC_MIX,
      ST_WRITE
   } state_type;

endpackage

// ----- rtl/sfdl_ram.sv -----
// ----------------------------------------------------------------------------
// Stereo feedback delay RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sfdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/stereo_feedback_delay_lowpass.sv -----
// ----------------------------------------------------------------------------
// Stereo feedback delay line with lowpass in the feedback path
// One shared 25x17 multiplier serves seven sequencer steps per channel; a new pair
// is accepted only in IDLE, and rsp_valid rises once WRITE finds the output free.
// Reset is synchronous; ring entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
`include "stereo_feedback_delay_lowpass_macros.svh"

module stereo_feedback_delay_lowpass #(
   parameter int DELAY_DEPTH = 32768
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_left_in,
   input  logic signed [15:0] req_right_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam logic [16:0] DMAX = 17'(DELAY_DEPTH - 1);
   localparam logic [AW-1:0] DELAY_INIT =
      (sfdl_pkg::DELAY_RESET > DELAY_DEPTH - 1) ? AW'(DELAY_DEPTH - 1)
                                                : AW'(sfdl_pkg::DELAY_RESET);
   localparam logic signed [27:0] LP_MAX = 28'sd8388607;
   localparam logic signed [27:0] LP_MIN = -28'sd8388608;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Configuration registers hold the already clamped values.
   logic [AW-1:0] delay_ff;
   logic [14:0]   fb_ff;
   logic [15:0]   wet_ff;
   logic [15:0]   coeff_ff;
   logic [16:0]   csr_dly_ext;
   logic [14:0]   csr_fb;
   logic [15:0]   csr_u16;

   assign csr_dly_ext = {2'b00, csr_wdata[14:0]};
   assign csr_fb = (csr_wdata[14:0] > 15'(sfdl_pkg::FB_MAX)) ? 15'(sfdl_pkg::FB_MAX)
                                                              : csr_wdata[14:0];
   assign csr_u16 = (csr_wdata > 16'(sfdl_pkg::UNITY)) ? 16'(sfdl_pkg::UNITY) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_INIT;
         fb_ff    <= 15'(sfdl_pkg::FB_RESET);
         wet_ff   <= 16'(sfdl_pkg::WET_RESET);
         coeff_ff <= 16'(sfdl_pkg::COEFF_RESET);
      end else if (csr_we) begin
         unique case (sfdl_pkg::csr_index_type'(csr_index))
            sfdl_pkg::CSR_DELAY: begin
               delay_ff <= (csr_dly_ext > DMAX) ? DMAX[AW-1:0] : csr_dly_ext[AW-1:0];
            end
            sfdl_pkg::CSR_FEEDBACK: begin
               fb_ff <= csr_fb;
            end
            sfdl_pkg::CSR_WET: begin
               wet_ff <= csr_u16;
            end
            sfdl_pkg::CSR_COEFF: begin
               coeff_ff <= csr_u16;
            end
            default: begin
            end
         endcase
      end
   end

   sfdl_pkg::state_type state_ff, state_in;

   logic               ch_ff;
   logic [AW-1:0]      wi_ff;
   logic               filled_ff;
   logic               hit_ff;
   logic signed [15:0] in_l_ff, in_r_ff;
   logic signed [15:0] dly_l_ff, dly_r_ff;
   logic signed [23:0] lp_l_ff, lp_r_ff;
   logic signed [15:0] wr_l_ff, wr_r_ff;
   logic signed [15:0] mix_l_ff, mix_r_ff;
   logic signed [41:0] prod_ff;
   logic signed [41:0] acc_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_l_ff, rsp_r_ff;

   logic               accept;
   logic               out_free;
   logic               ram_we;
   logic [AW:0]        rd_sum;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        ram_rdata;
   logic signed [15:0] cur_in, cur_dly;
   logic signed [23:0] cur_lp;
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] mul_res;
   logic signed [41:0] lp_step;
   logic signed [27:0] lp_sum;
   logic signed [23:0] lp_new;
   logic signed [41:0] fb_rnd;
   logic signed [17:0] fb_sum;
   logic signed [42:0] mix_sum;
   logic signed [42:0] mix_rnd;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rd_sum = (wi_ff >= delay_ff)
                   ? ({1'b0, wi_ff} - {1'b0, delay_ff})
                   : ({1'b0, wi_ff} + (AW+1)'(DELAY_DEPTH) - {1'b0, delay_ff});
   assign rd_addr = rd_sum[AW-1:0];

   sfdl_ram #(
      .WIDTH(32),
      .DEPTH(DELAY_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wi_ff),
      .wdata ({wr_l_ff, wr_r_ff}),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign cur_in  = ch_ff ? in_r_ff  : in_l_ff;
   assign cur_dly = ch_ff ? dly_r_ff : dly_l_ff;
   assign cur_lp  = ch_ff ? lp_r_ff  : lp_l_ff;

   assign mul_res = 42'(mul_a) * 42'(mul_b);

   assign lp_step = (prod_ff + 42'sd16384) >>> 15;
   assign lp_sum  = lp_step[27:0] + {{4{cur_lp[23]}}, cur_lp};
   assign lp_new  = (lp_sum > LP_MAX) ? LP_MAX[23:0]
                  : ((lp_sum < LP_MIN) ? LP_MIN[23:0] : lp_sum[23:0]);

   assign fb_rnd = (prod_ff + 42'sd4194304) >>> 23;
   assign fb_sum = fb_rnd[17:0] + {{2{cur_in[15]}}, cur_in};

   assign mix_sum = {acc_ff[41], acc_ff} + {prod_ff[41], prod_ff};
   assign mix_rnd = (mix_sum + 43'sd16384) >>> 15;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfdl_pkg::ST_IDLE:    if (req_valid) state_in = sfdl_pkg::ST_LOAD;
         sfdl_pkg::ST_LOAD:    state_in = sfdl_pkg::ST_MUL_LP;
         sfdl_pkg::ST_MUL_LP:  state_in = sfdl_pkg::ST_ACC_LP;
         sfdl_pkg::ST_ACC_LP:  state_in = sfdl_pkg::ST_MUL_FB;
         sfdl_pkg::ST_MUL_FB:  state_in = sfdl_pkg::ST_ACC_FB;
         sfdl_pkg::ST_ACC_FB:  state_in = sfdl_pkg::ST_MUL_DRY;
         sfdl_pkg::ST_MUL_DRY: state_in = sfdl_pkg::ST_MUL_WET;
         sfdl_pkg::ST_MUL_WET: state_in = sfdl_pkg::ST_ACC_MIX;
         sfdl_pkg::ST_ACC_MIX: begin
            state_in = ch_ff ? sfdl_pkg::ST_WRITE : sfdl_pkg::ST_MUL_LP;
         end
         sfdl_pkg::ST_WRITE:   if (out_free) state_in = sfdl_pkg::ST_IDLE;
         default:              state_in = sfdl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         sfdl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sfdl_pkg::ST_MUL_LP: begin
            mul_a = {cur_dly[15], cur_dly, 8'h00} - {cur_lp[23], cur_lp};
            mul_b = {1'b0, coeff_ff};
         end
         sfdl_pkg::ST_MUL_FB: begin
            mul_a = {cur_lp[23], cur_lp};
            mul_b = {2'b00, fb_ff};
         end
         sfdl_pkg::ST_MUL_DRY: begin
            mul_a = {{9{cur_in[15]}}, cur_in};
            mul_b = 17'(sfdl_pkg::UNITY) - {1'b0, wet_ff};
         end
         sfdl_pkg::ST_MUL_WET: begin
            mul_a = {{9{cur_dly[15]}}, cur_dly};
            mul_b = {1'b0, wet_ff};
         end
         sfdl_pkg::ST_WRITE: begin
            ram_we = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfdl_pkg::ST_IDLE;
         ch_ff        <= 1'b0;
         wi_ff        <= '0;
         filled_ff    <= 1'b0;
         lp_l_ff      <= '0;
         lp_r_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            ch_ff <= 1'b0;
         end else if (state_ff == sfdl_pkg::ST_ACC_MIX) begin
            ch_ff <= 1'b1;
         end
         if (state_ff == sfdl_pkg::ST_ACC_LP) begin
            if (ch_ff) begin
               lp_r_ff <= lp_new;
            end else begin
               lp_l_ff <= lp_new;
            end
         end
         if (ram_we) begin
            if (wi_ff == AW'(DELAY_DEPTH - 1)) begin
               wi_ff     <= '0;
               filled_ff <= 1'b1;
            end else begin
               wi_ff <= wi_ff + 1'b1;
            end
         end
         if (ram_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_res;
      if (accept) begin
         in_l_ff <= req_left_in;
         in_r_ff <= req_right_in;
         hit_ff  <= filled_ff || (rd_addr < wi_ff);
      end
      if (state_ff == sfdl_pkg::ST_LOAD) begin
         dly_l_ff <= hit_ff ? ram_rdata[31:16] : 16'sh0000;
         dly_r_ff <= hit_ff ? ram_rdata[15:0]  : 16'sh0000;
      end
      if (state_ff == sfdl_pkg::ST_ACC_FB) begin
         if (ch_ff) begin
            wr_r_ff <= sat16(fb_sum);
         end else begin
            wr_l_ff <= sat16(fb_sum);
         end
      end
      if (state_ff == sfdl_pkg::ST_MUL_WET) begin
         acc_ff <= prod_ff;
      end
      if (state_ff == sfdl_pkg::ST_ACC_MIX) begin
         if (ch_ff) begin
            mix_r_ff <= sat16(mix_rnd[17:0]);
         end else begin
            mix_l_ff <= sat16(mix_rnd[17:0]);
         end
      end
      if (ram_we) begin
         rsp_l_ff <= mix_l_ff;
         rsp_r_ff <= mix_r_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   `SFDL_ASSERT_NXT(a_accept_loads, clock, reset, accept, state_ff == sfdl_pkg::ST_LOAD)
   `SFDL_ASSERT_NXT(a_write_advances, clock, reset, ram_we, wi_ff != $past(wi_ff))
   `SFDL_ASSERT_IMP(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff), $past(ram_we))

endmodule

// ----- tb/sv/stereo_feedback_delay_lowpass_tb.sv -----
// ----------------------------------------------------------------------------
// Stereo feedback delay line testbench
// Drives stereo sample pairs through the delay block under several register
// settings, predicts every mixed output pair with a local model of the rings,
// the lowpass states and the mix, and compares each result transaction with
// the oldest prediction. The request side idles and the result side stalls in random
// bursts, except during the steady stream test.
module stereo_feedback_delay_lowpass_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = 32768;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } stereo_pair_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_left_in = '0;
   logic signed [15:0] req_right_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   logic signed [15:0] left_ring [RING_DEPTH];
   logic signed [15:0] right_ring [RING_DEPTH];
   logic [14:0]        write_ptr;
   logic signed [23:0] left_state;
   logic signed [23:0] right_state;
   logic [14:0]        delay_q;
   logic [14:0]        feedback_q;
   logic [15:0]        wet_q;
   logic [15:0]        coeff_q;

   stereo_pair_type expected_pairs [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;

   stereo_feedback_delay_lowpass #(
      .DELAY_DEPTH(RING_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic longint round_half_up(input longint value, input int shift);
      return (value + (longint'(1) <<< (shift - 1))) >>> shift;
   endfunction

   function automatic longint saturate(input longint value, input longint lo, input longint hi);
      return (value < lo) ? lo : ((value > hi) ? hi : value);
   endfunction

   function automatic void filter_channel(
      input  logic signed [15:0] in_sample,
      input  logic signed [15:0] delayed,
      inout  logic signed [23:0] lp_state,
      input  int                 fb,
      input  int                 wet,
      input  int                 co,
      output logic signed [15:0] ring_value,
      output logic signed [15:0] mixed
   );
      longint target;
      longint lp_step;
      longint filtered;
      longint fb_term;
      longint mix_sum;
      target   = longint'(delayed) * 256;
      lp_step  = round_half_up(longint'(co) * (target - longint'(lp_state)), 15);
      filtered = saturate(longint'(lp_state) + lp_step, -8388608, 8388607);
      fb_term  = round_half_up(filtered * longint'(fb), 23);
      lp_state = filtered[23:0];
      ring_value = 16'(saturate(longint'(in_sample) + fb_term, -32768, 32767));
      mix_sum = longint'(in_sample) * longint'(sfdl_pkg::UNITY - wet)
              + longint'(delayed) * longint'(wet);
      mixed = 16'(saturate(round_half_up(mix_sum, 15), -32768, 32767));
   endfunction

   task automatic predict_pair(input logic signed [15:0] left_in, input logic signed [15:0] right_in);
      logic [14:0]        read_ptr;
      logic signed [15:0] left_new;
      logic signed [15:0] right_new;
      stereo_pair_type    result;
      int                 fb;
      int                 wet;
      int                 co;
      // A 15-bit delay never exceeds the deepest valid delay of the ring.
      read_ptr = write_ptr - delay_q;
      fb  = (feedback_q > sfdl_pkg::FB_MAX) ? sfdl_pkg::FB_MAX : int'(feedback_q);
      wet = (wet_q > sfdl_pkg::UNITY) ? sfdl_pkg::UNITY : int'(wet_q);
      co  = (coeff_q > sfdl_pkg::UNITY) ? sfdl_pkg::UNITY : int'(coeff_q);
      filter_channel(left_in, left_ring[read_ptr], left_state, fb, wet, co,
                     left_new, result.left);
      filter_channel(right_in, right_ring[read_ptr], right_state, fb, wet, co,
                     right_new, result.right);
      left_ring[write_ptr]  = left_new;
      right_ring[write_ptr] = right_new;
      write_ptr = write_ptr + 15'd1;
      expected_pairs.push_back(result);
   endtask

   task automatic send_pair(input logic signed [15:0] left_in, input logic signed [15:0] right_in);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= left_in;
      req_right_in <= right_in;
      do @(posedge clock); while (!req_ready);
      predict_pair(left_in, right_in);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input sfdl_pkg::csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         sfdl_pkg::CSR_DELAY:    delay_q    = value[14:0];
         sfdl_pkg::CSR_FEEDBACK: feedback_q = value[14:0];
         sfdl_pkg::CSR_WET:      wet_q      = value;
         sfdl_pkg::CSR_COEFF:    coeff_q    = value;
         default:                ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(input logic [15:0] delay, input logic [15:0] fb,
                          input logic [15:0] wet, input logic [15:0] co);
      wait_idle();
      csr_write(sfdl_pkg::CSR_DELAY, delay);
      csr_write(sfdl_pkg::CSR_FEEDBACK, fb);
      csr_write(sfdl_pkg::CSR_WET, wet);
      csr_write(sfdl_pkg::CSR_COEFF, co);
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2:       return 16'($urandom_range(0, 64)) - 16'sd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_gain();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'(sfdl_pkg::UNITY);
         2:       return 16'($urandom_range(sfdl_pkg::UNITY + 1, 65535));
         default: return 16'($urandom_range(0, sfdl_pkg::UNITY));
      endcase
   endfunction

   function automatic logic [15:0] random_delay();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'd0;
         default: return 16'($urandom_range(1, 48));
      endcase
   endfunction

   function automatic logic [15:0] random_feedback();
      if ($urandom_range(0, 3) == 0) return 16'($urandom_range(sfdl_pkg::FB_MAX, 65535));
      return 16'($urandom_range(0, sfdl_pkg::FB_MAX));
   endfunction

   task automatic test_reset_state();
      send_pair(16'sh7FFF, -16'sh8000);
      send_pair(-16'sh8000, 16'sh7FFF);
      send_pair(16'sh0000, -16'sh0001);
      send_pair(16'sh0001, 16'sh0000);
   endtask

   task automatic test_saturation();
      set_all(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (4) send_pair(16'sh7FFF, -16'sh8000);
      repeat (3) send_pair(-16'sh8000, 16'sh7FFF);
   endtask

   task automatic test_zero_delay();
      set_all(16'd0, 16'(sfdl_pkg::FB_MAX), 16'(sfdl_pkg::UNITY), 16'd10643);
      repeat (3) send_pair(random_sample(), random_sample());
   endtask

   task automatic test_long_delay();
      set_all(16'hFFFF, 16'd13107, 16'd16384, 16'd0);
      repeat (3) send_pair(random_sample(), random_sample());
   endtask

   task automatic test_half_mix();
      set_all(16'd2, 16'd13107, 16'd16384, 16'(sfdl_pkg::COEFF_RESET));
      repeat (3) begin
         send_pair(16'sh7FFF, -16'sh0001);
         send_pair(-16'sh8000, 16'sh0001);
      end
   endtask

   task automatic test_random_phases();
      repeat (10) begin
         set_all(random_delay(), random_feedback(), random_gain(), random_gain());
         repeat (55) send_pair(random_sample(), random_sample());
      end
   endtask

   task automatic test_steady_stream();
      set_all(16'($urandom_range(1, 16)), random_feedback(), random_gain(), random_gain());
      idle_on = 1'b0;
      repeat (60) send_pair(random_sample(), random_sample());
   endtask

   always @(posedge clock) begin
      stereo_pair_type expected;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("Unexpected result transaction: left %0d right %0d",
                           rsp_left_out, rsp_right_out);
               error_count++;
            end else begin
               expected = expected_pairs.pop_front();
               if (rsp_left_out !== expected.left || rsp_right_out !== expected.right) begin
                  if (error_count < MAX_REPORTS)
                     $display("Mismatch: expected left %0d right %0d, got left %0d right %0d",
                              expected.left, expected.right, rsp_left_out, rsp_right_out);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 18);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         left_ring[i]  = '0;
         right_ring[i] = '0;
      end
      write_ptr   = '0;
      left_state  = '0;
      right_state = '0;
      delay_q     = 15'(sfdl_pkg::DELAY_RESET);
      feedback_q  = 15'(sfdl_pkg::FB_RESET);
      wet_q       = 16'(sfdl_pkg::WET_RESET);
      coeff_q     = 16'(sfdl_pkg::COEFF_RESET);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_saturation();
      test_zero_delay();
      test_long_delay();
      test_half_mix();
      test_random_phases();
      test_steady_stream();
      wait_idle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sfdl_pkg.sv
rtl/sfdl_ram.sv
rtl/stereo_feedback_delay_lowpass.sv
tb/sv/stereo_feedback_delay_lowpass_tb.sv
